FILE: hw/rtl/pbp_pkg.sv
package pbp_pkg;

   localparam int Boxes = 16;
   localparam int WordsPerBox = 15;
   localparam int Depth = Boxes * WordsPerBox;
   localparam int AddrW = $clog2(Depth);
   localparam int IdxW = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_MUL,
      ST_EVAL,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       wr_en;
      logic       rd_en;
      logic [3:0] rd_word;
      logic       cap_center;
      logic       mul;
      logic [1:0] mul_axis;
      logic [1:0] mul_comp;
      logic       acc_clear;
      logic       acc_add;
      logic       eval;
      logic [1:0] eval_axis;
      logic       emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_test;
      logic box_ok;
      logic word_ok;
   } stat_type;

   localparam logic [3:0] WordAxis0 = 4'd3;
   localparam logic [3:0] WordHalf0 = 4'd12;

endpackage

FILE: hw/rtl/pbp_ctrl.sv
module pbp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  pbp_pkg::stat_type  stat,
   output pbp_pkg::cmd_type   cmd
);

   pbp_pkg::state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [1:0] sweep_axis, sweep_comp;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbp_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // split the axis word step into axis and component
   always_comb begin
      if (step_ff >= 4'd6) begin
         sweep_axis = 2'd2;
         sweep_comp = 2'(step_ff - 4'd6);
      end else if (step_ff >= 4'd3) begin
         sweep_axis = 2'd1;
         sweep_comp = 2'(step_ff - 4'd3);
      end else begin
         sweep_axis = 2'd0;
         sweep_comp = step_ff[1:0];
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      busy     = (state_ff != pbp_pkg::ST_IDLE);
      unique case (state_ff)
         pbp_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = pbp_pkg::ST_READ;
            end
         end
         pbp_pkg::ST_READ: begin
            if (!stat.is_test) begin
               cmd.wr_en = stat.box_ok && stat.word_ok;
               state_in  = pbp_pkg::ST_DONE;
            end else if (!stat.box_ok) begin
               state_in = pbp_pkg::ST_DONE;
            end else begin
               // read center x/y/z, one word a cycle
               cmd.rd_en   = 1'b1;
               cmd.rd_word = step_ff;
               step_in     = 4'd0;
               state_in    = pbp_pkg::ST_DIFF;
            end
         end
         pbp_pkg::ST_DIFF: begin
            // step counts reads issued beyond the first; read data is registered and arrives the cycle after its read
            cmd.cap_center = 1'b1;
            cmd.mul_comp   = step_ff[1:0];
            if (step_ff < 4'd2) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_word = step_ff + 4'd1;
               step_in     = step_ff + 4'd1;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_word = pbp_pkg::WordAxis0;
               cmd.acc_clear = 1'b1;
               step_in     = 4'd0;
               state_in    = pbp_pkg::ST_MUL;
            end
         end
         pbp_pkg::ST_MUL: begin
            // axis word step arrives; multiply, then add next cycle
            cmd.mul      = 1'b1;
            cmd.mul_axis = sweep_axis;
            cmd.mul_comp = sweep_comp;
            cmd.acc_add  = (step_ff != 4'd0);
            if (step_ff < 4'd8) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_word = pbp_pkg::WordAxis0 + step_ff + 4'd1;
               step_in     = step_ff + 4'd1;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_word = pbp_pkg::WordHalf0;
               step_in     = 4'd0;
               state_in    = pbp_pkg::ST_EVAL;
            end
         end
         pbp_pkg::ST_EVAL: begin
            // half word k arrives; last product added on first cycle
            cmd.acc_add   = (step_ff == 4'd0);
            cmd.eval      = 1'b1;
            cmd.eval_axis = step_ff[1:0];
            if (step_ff < 4'd2) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_word = pbp_pkg::WordHalf0 + step_ff + 4'd1;
               step_in     = step_ff + 4'd1;
            end else begin
               step_in  = 4'd0;
               state_in = pbp_pkg::ST_DONE;
            end
         end
         pbp_pkg::ST_DONE: begin
            cmd.emit = 1'b1;
            state_in = pbp_pkg::ST_IDLE;
         end
         default: state_in = pbp_pkg::ST_IDLE;
      endcase
   end

endmodule

FILE: hw/rtl/pbp_datapath.sv
module pbp_datapath (
   input  logic                clock,
   input  logic                reset,
   input  pbp_pkg::cmd_type    cmd,
   output pbp_pkg::stat_type   stat,
   input  logic [30:0]         margin,
   input  logic                req_mode,
   input  logic [3:0]          req_box_index,
   input  logic [3:0]          req_word_index,
   input  logic signed [31:0]  req_word_value,
   input  logic signed [31:0]  req_point_x,
   input  logic signed [31:0]  req_point_y,
   input  logic signed [31:0]  req_point_z,
   output logic                rsp_valid,
   output logic                rsp_inside_res,
   output logic [30:0]         rsp_depth,
   output logic [1:0]          rsp_hit_axis,
   output logic signed [31:0]  rsp_normal_x,
   output logic signed [31:0]  rsp_normal_y,
   output logic signed [31:0]  rsp_normal_z
);

   logic [31:0] mem [pbp_pkg::Depth];
   logic signed [31:0] rd_ff;

   logic        mode_ff;
   logic [3:0]  box_ff, word_ff;
   logic signed [31:0] val_ff;
   logic signed [31:0] pt_ff [3];
   logic signed [32:0] d_ff [3];
   logic signed [64:0] prod_ff;
   // sum of three floored products needs 50 bits
   logic signed [49:0] acc_ff, acc_in;
   logic signed [49:0] q_ff [3];
   logic        ok_ff, ok_in;
   logic signed [33:0] best_ff, best_in;
   logic [1:0]  axis_ff, axis_in;
   logic        sneg_ff, sneg_in;
   logic        valid_ff;

   logic [pbp_pkg::AddrW-1:0] base, rd_addr, wr_addr;
   logic [pbp_pkg::AddrW+3:0] base_w;

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         box_ff   <= req_box_index;
         word_ff  <= req_word_index;
         val_ff   <= req_word_value;
         pt_ff[0] <= req_point_x;
         pt_ff[1] <= req_point_y;
         pt_ff[2] <= req_point_z;
      end
   end

   assign stat.is_test = mode_ff;
   assign stat.box_ok  = (32'(box_ff) < 32'(pbp_pkg::Boxes));
   assign stat.word_ok = (32'(word_ff) < 32'(pbp_pkg::WordsPerBox));

   // box table, one port each way
   assign base_w  = (pbp_pkg::AddrW+4)'(box_ff) * (pbp_pkg::AddrW+4)'(pbp_pkg::WordsPerBox);
   assign base    = base_w[pbp_pkg::AddrW-1:0];
   assign rd_addr = base + pbp_pkg::AddrW'(cmd.rd_word);
   assign wr_addr = base + pbp_pkg::AddrW'(word_ff);

   always_ff @(posedge clock) begin
      if (cmd.wr_en) mem[wr_addr] <= val_ff;
      if (cmd.rd_en) rd_ff <= mem[rd_addr];
   end

   // point minus center
   always_ff @(posedge clock) begin
      if (cmd.cap_center)
         d_ff[cmd.mul_comp] <= 33'(pt_ff[cmd.mul_comp]) - 33'(rd_ff);
   end

   // product then floored accumulate
   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= 65'(d_ff[cmd.mul_comp]) * 65'(rd_ff);
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_add) acc_in = acc_ff + 50'(prod_ff >>> 16);
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (cmd.mul && cmd.mul_comp == 2'd0 && cmd.acc_add) begin
         // axis boundary: close previous axis sum, start fresh
         q_ff[cmd.mul_axis - 2'd1] <= acc_in;
         acc_ff <= '0;
      end else if (cmd.eval && cmd.acc_add) begin
         q_ff[2] <= acc_in;
         acc_ff  <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // compare against grown half size, keep least penetration
   logic signed [49:0] q_cur, mag;
   logic signed [49:0] e_k, pen;
   always_comb begin
      q_cur = (cmd.eval_axis == 2'd2 && cmd.acc_add) ? acc_in : q_ff[cmd.eval_axis];
      mag   = q_cur[49] ? -q_cur : q_cur;
      e_k   = 50'(rd_ff) + 50'(margin);
      pen   = e_k - mag;
      ok_in   = ok_ff;
      best_in = best_ff;
      axis_in = axis_ff;
      sneg_in = sneg_ff;
      if (cmd.eval) begin
         if (mag >= e_k) ok_in = 1'b0;
         if (cmd.eval_axis == 2'd0 || 34'(pen) < best_ff) begin
            best_in = 34'(pen);
            axis_in = cmd.eval_axis;
            sneg_in = q_cur[49];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ok_ff <= 1'b1;
      end else begin
         ok_ff <= ok_in;
      end
      best_ff <= best_in;
      axis_ff <= axis_in;
      sneg_ff <= sneg_in;
   end

   // axis words of the winner re-read after the sweep would cost cycles; keep copies
   logic signed [31:0] ax_ff [9];
   always_ff @(posedge clock) begin
      if (cmd.mul) ax_ff[4'(cmd.mul_axis) * 4'd3 + 4'(cmd.mul_comp)] <= rd_ff;
   end

   function automatic logic signed [31:0] sgn_sat(input logic signed [31:0] v,
                                                   input logic neg);
      if (!neg) return v;
      if (v == 32'sh8000_0000) return 32'sh7fff_ffff;
      return -v;
   endfunction

   // result register
   logic hit;
   assign hit = mode_ff && stat.box_ok && ok_ff;
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= cmd.emit;
      if (cmd.emit) begin
         rsp_inside_res <= hit;
         rsp_depth      <= hit ? (best_ff > 34'sh7fff_ffff ? 31'h7fff_ffff : best_ff[30:0]) : '0;
         rsp_hit_axis   <= hit ? axis_ff : '0;
         rsp_normal_x   <= hit ? sgn_sat(ax_ff[4'(axis_ff)*4'd3], sneg_ff) : '0;
         rsp_normal_y   <= hit ? sgn_sat(ax_ff[4'(axis_ff)*4'd3+4'd1], sneg_ff) : '0;
         rsp_normal_z   <= hit ? sgn_sat(ax_ff[4'(axis_ff)*4'd3+4'd2], sneg_ff) : '0;
      end
   end
   assign rsp_valid = valid_ff;

endmodule

FILE: hw/rtl/point_box_penetration_unit.sv
// point_box_penetration_unit
// Oriented-box table with a point containment and penetration test.
// Request channel: start with req_* fields, taken when start is high and busy low.
// mode 0 writes one word of one box, mode 1 tests a point against a box.
// Result channel: one result per item, shown for one cycle with rsp_valid;
// the receiver cannot stall it and must take it in that cycle.
// Config: csr_valid/csr_ready write contact_margin; csr_ready is always high.
// A test is paced by the single read port of the box table (15 words
// read one a cycle) and the shared multiplier.
// A new item is accepted the cycle after the result strobe.
// Reset (synchronous) clears the controller and contact_margin; box words
// are undefined until written.
module point_box_penetration_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_mode,
   input  logic [3:0]         req_box_index,
   input  logic [3:0]         req_word_index,
   input  logic signed [31:0] req_word_value,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [30:0]        csr_data,
   output logic               rsp_valid,
   output logic               rsp_inside_res,
   output logic [30:0]        rsp_depth,
   output logic [1:0]         rsp_hit_axis,
   output logic signed [31:0] rsp_normal_x,
   output logic signed [31:0] rsp_normal_y,
   output logic signed [31:0] rsp_normal_z
);

   pbp_pkg::cmd_type  cmd;
   pbp_pkg::stat_type stat;
   logic [30:0] margin_ff;
   logic        ctrl_busy, rsp_pend;

   // margin register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset)          margin_ff <= '0;
      else if (csr_valid) margin_ff <= csr_data;
   end

   assign rsp_pend = 1'b0;
   assign busy = ctrl_busy | rsp_pend | rsp_valid;

   pbp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start && !rsp_valid),
      .busy  (ctrl_busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   pbp_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .margin         (margin_ff),
      .req_mode       (req_mode),
      .req_box_index  (req_box_index),
      .req_word_index (req_word_index),
      .req_word_value (req_word_value),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .rsp_valid      (rsp_valid),
      .rsp_inside_res (rsp_inside_res),
      .rsp_depth      (rsp_depth),
      .rsp_hit_axis   (rsp_hit_axis),
      .rsp_normal_x   (rsp_normal_x),
      .rsp_normal_y   (rsp_normal_y),
      .rsp_normal_z   (rsp_normal_z)
   );

endmodule

FILE: hw/rtl/pbp_checker.sv
module pbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_inside_res,
   input logic [30:0] rsp_depth,
   input logic [1:0]  rsp_hit_axis
);

   // an accepted item makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("not busy after accept");

   // no result while busy is low and its past value is low too
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !busy && $past(!busy) |-> !rsp_valid) else $error("result without item");

   // outside results carry zero fields
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_res |-> rsp_depth == '0 && rsp_hit_axis == '0)
      else $error("outside result not zero");

   // axis is never three
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_axis != 2'd3) else $error("bad axis");

endmodule

bind point_box_penetration_unit pbp_checker u_pbp_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_inside_res (rsp_inside_res),
   .rsp_depth      (rsp_depth),
   .rsp_hit_axis   (rsp_hit_axis)
);
